FILE: src/bcfo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfo_pkg: shared types and constants for the bandwidth cluster fallback order
// Types, limits, request and result structs, controller command/status.
// ----------------------------------------------------------------------------
package bcfo_pkg;

    localparam int MAX_NODES_DEF   = 8;
    localparam int MAX_SOCKETS_DEF = 8;
    localparam int BW_W            = 24;
    localparam int DIST_W          = 8;
    localparam int CFG_W           = 7;
    localparam int CFG_IDX_W       = 2;
    localparam logic [6:0] PCT_FULL = 7'd100;

    typedef enum logic [1:0] {
        ACT_LOAD_BW   = 2'd0,
        ACT_LOAD_DIST = 2'd1,
        ACT_COMPUTE   = 2'd2,
        ACT_NONE      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_NODE_COUNT   = 2'd0,
        CFG_SOCKET_COUNT = 2'd1,
        CFG_TOLERANCE    = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  node_index;
        logic [2:0]  socket_index;
        logic [23:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0] socket_id;
        logic [2:0] position;
        logic [2:0] node_id;
        logic       last;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_MUL,
        ST_CLUS,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic init_sort;
        logic sort_step;
        logic mul_step;
        logic clus_step;
        logic scan_init;
        logic scan_step;
        logic emit_step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sort_done;
        logic clus_done;
        logic scan_done;
        logic emit_done;
        logic all_done;
    } t_sts;

endpackage

FILE: src/bcfo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfo_ctrl: sequencer for a compute request
// Steps the datapath through sort, clustering, per-cluster scan and emit.
// ----------------------------------------------------------------------------
module bcfo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  bcfo_pkg::t_sts    i_sts,
    output bcfo_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import bcfo_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_go) n_state = ST_SORT;
            ST_SORT: if (i_sts.sort_done) n_state = ST_MUL;
            ST_MUL:  n_state = ST_CLUS;
            ST_CLUS: begin
                if (i_sts.clus_done) n_state = ST_SCAN;
                else n_state = ST_MUL;
            end
            ST_SCAN: if (i_sts.scan_done) n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_sts.all_done) n_state = ST_IDLE;
                else if (i_sts.emit_done) n_state = ST_SCAN;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: o_cmd.init_sort = i_go;
            ST_SORT: o_cmd.sort_step = 1'b1;
            ST_MUL:  o_cmd.mul_step  = 1'b1;
            ST_CLUS: begin
                o_cmd.clus_step = 1'b1;
                o_cmd.scan_init = i_sts.clus_done;
            end
            ST_SCAN: o_cmd.scan_step = 1'b1;
            ST_EMIT: o_cmd.emit_step = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    // a compute never starts while another runs
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd.init_sort)
        else $error("init while busy");
    a_emit_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && $past(r_state) != ST_EMIT) |-> $past(r_state) == ST_SCAN)
        else $error("emit not after scan");
    a_sort_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_SORT) |-> $past(i_go))
        else $error("sort without go");

endmodule

FILE: src/bcfo_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfo_dp: stores, sort, clustering and list datapath
// Insertion sort one element per cycle, one multiply pair per cluster step,
// then per socket and cluster a distance sort of the members and emission.
// The distance store is read one entry a cycle through a read register.
// ----------------------------------------------------------------------------
module bcfo_dp #(
    parameter int MAX_NODES   = bcfo_pkg::MAX_NODES_DEF,
    parameter int MAX_SOCKETS = bcfo_pkg::MAX_SOCKETS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  bcfo_pkg::t_req    i_req,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [6:0]        i_cfg_data,
    input  bcfo_pkg::t_cmd    i_cmd,
    output bcfo_pkg::t_sts    o_sts,
    output logic              o_res_valid,
    output bcfo_pkg::t_res    o_res
);
    import bcfo_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int SW = (MAX_SOCKETS > 1) ? $clog2(MAX_SOCKETS) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int SCW = $clog2(MAX_SOCKETS + 1);

    logic [3:0]        r_node_count, r_socket_count;
    logic [6:0]        r_tol;
    logic [BW_W-1:0]   r_bw   [MAX_NODES];
    logic [DIST_W-1:0] r_dist [MAX_SOCKETS][MAX_NODES];
    logic [NW-1:0]     r_clus [MAX_NODES];
    logic [NW-1:0]     r_ord  [MAX_NODES];

    logic [CW-1:0]  c_n;
    logic [SCW-1:0] c_sc;

    // clamped counts
    always_comb begin
        if (r_node_count == 4'd0) c_n = CW'(1);
        else if (32'(r_node_count) > MAX_NODES) c_n = CW'(MAX_NODES);
        else c_n = CW'(r_node_count);
        if (r_socket_count == 4'd0) c_sc = SCW'(1);
        else if (32'(r_socket_count) > MAX_SOCKETS) c_sc = SCW'(MAX_SOCKETS);
        else c_sc = SCW'(r_socket_count);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count   <= 4'd8;
            r_socket_count <= 4'd1;
            r_tol          <= 7'd5;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NODE_COUNT:   r_node_count   <= i_cfg_data[3:0];
                CFG_SOCKET_COUNT: r_socket_count <= i_cfg_data[3:0];
                CFG_TOLERANCE:    r_tol          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // load requests into the stores
    always_ff @(posedge i_clk) begin
        if (i_load && i_req.action == ACT_LOAD_BW
            && 32'(i_req.node_index) < MAX_NODES) begin
            r_bw[i_req.node_index[NW-1:0]] <= i_req.value;
        end
        if (i_load && i_req.action == ACT_LOAD_DIST
            && 32'(i_req.node_index) < MAX_NODES
            && 32'(i_req.socket_index) < MAX_SOCKETS) begin
            r_dist[i_req.socket_index[SW-1:0]][i_req.node_index[NW-1:0]]
                <= i_req.value[DIST_W-1:0];
        end
    end

    // ---------------- bandwidth insertion sort -----------------
    // one new element inserted per cycle: shift all larger entries up
    logic [CW-1:0] r_si;
    logic [BW_W-1:0] c_vbw;
    assign c_vbw = r_bw[r_si[NW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_sort) begin
            r_si <= '0;
        end else if (i_cmd.sort_step) begin
            for (int k = 0; k < MAX_NODES; k++) begin
                if (CW'(k) <= r_si) begin
                    if (CW'(k) == r_si) begin
                        if (k == 0 || !(r_bw[r_ord[k-1 > 0 ? k-1 : 0]] > c_vbw))
                            r_ord[k] <= r_si[NW-1:0];
                        else
                            r_ord[k] <= r_ord[k-1 > 0 ? k-1 : 0];
                    end else if (r_bw[r_ord[k]] > c_vbw) begin
                        if (k == 0 || !(r_bw[r_ord[k-1 > 0 ? k-1 : 0]] > c_vbw))
                            r_ord[k] <= r_si[NW-1:0];
                        else
                            r_ord[k] <= r_ord[k-1 > 0 ? k-1 : 0];
                    end
                end
            end
            r_si <= r_si + CW'(1);
        end
    end
    assign o_sts.sort_done = (r_si + CW'(1) >= c_n) && i_cmd.sort_step;

    // ---------------- clustering walk -----------------
    // base starts at fastest node; each step one multiply pair, one compare
    logic [CW-1:0]   r_ci;      // index into r_ord of next node, counts down
    logic [NW-1:0]   r_base;
    logic [NW-1:0]   r_ncl;
    logic [31:0]     r_lhs, r_rhs;
    logic [NW-1:0]   c_nd;
    logic [7:0]      c_pct;

    assign c_nd  = r_ord[r_ci[NW-1:0]];
    // a tolerance of 100 or more leaves no positive left side
    assign c_pct = (r_tol >= PCT_FULL) ? 8'd0 : 8'(PCT_FULL) - 8'(r_tol);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_step && o_sts.sort_done) begin
            r_ci   <= c_n - CW'(1);
            r_ncl  <= '0;
        end else if (i_cmd.mul_step) begin
            if (r_ci == c_n - CW'(1)) begin
                r_base <= c_nd;
                r_lhs  <= '0;
                r_rhs  <= '1;
            end else begin
                r_lhs <= 32'(c_pct) * 32'(r_bw[r_base]);
                r_rhs <= 32'(8'd100) * 32'(r_bw[c_nd]);
            end
        end else if (i_cmd.clus_step) begin
            if (r_ci == c_n - CW'(1)) begin
                r_clus[c_nd] <= '0;
            end else if (r_lhs > r_rhs) begin
                r_base <= c_nd;
                r_ncl  <= r_ncl + NW'(1);
                r_clus[c_nd] <= r_ncl + NW'(1);
            end else begin
                r_clus[c_nd] <= r_ncl;
            end
            r_ci <= r_ci - CW'(1);
        end
    end
    assign o_sts.clus_done = i_cmd.clus_step && (r_ci == '0);

    // ---------------- per socket, per cluster list -----------------
    logic [SW-1:0]   r_sock;
    logic [NW-1:0]   r_cc;       // current cluster
    logic [CW-1:0]   r_scan;     // node scanned for insertion
    logic [CW-1:0]   r_cnt;
    logic [NW-1:0]   r_list [MAX_NODES];
    logic [DIST_W-1:0] r_ldist [MAX_NODES];
    logic [CW-1:0]   r_ei;
    logic [2:0]      r_pos;
    logic [DIST_W-1:0] r_dv;
    logic [SW-1:0]   c_rd_sock;
    logic [CW-1:0]   c_rd_scan;
    logic            c_mem;
    logic            c_last_grp;
    logic            c_last_cl;

    // read address follows the next socket and scan position
    always_comb begin
        c_rd_sock = r_sock;
        c_rd_scan = r_scan;
        if (i_cmd.scan_init) begin
            c_rd_sock = '0;
            c_rd_scan = '0;
        end else if (i_cmd.scan_step) begin
            c_rd_scan = r_scan + CW'(1);
        end else if (o_sts.emit_done) begin
            c_rd_scan = '0;
            if (c_last_cl) c_rd_sock = r_sock + SW'(1);
        end
    end

    // registered distance read, holds the entry of the node being scanned
    always_ff @(posedge i_clk) begin
        r_dv <= r_dist[c_rd_sock][c_rd_scan[NW-1:0]];
    end

    assign c_mem = (r_scan < c_n) && (r_clus[r_scan[NW-1:0]] == r_cc);
    assign c_last_cl = (r_cc == r_ncl);
    assign c_last_grp = c_last_cl && (SCW'(r_sock) + SCW'(1) == c_sc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_sock <= '0;
            r_cc   <= '0;
            r_scan <= '0;
            r_cnt  <= '0;
            r_pos  <= '0;
        end else if (i_cmd.scan_step) begin
            if (c_mem) begin
                for (int k = 0; k < MAX_NODES; k++) begin
                    if (CW'(k) <= r_cnt) begin
                        if (k == 0 || !(r_ldist[k-1 > 0 ? k-1 : 0] > r_dv)) begin
                            if (CW'(k) == r_cnt || r_ldist[k] > r_dv) begin
                                r_list[k]  <= r_scan[NW-1:0];
                                r_ldist[k] <= r_dv;
                            end
                        end else begin
                            r_list[k]  <= r_list[k-1 > 0 ? k-1 : 0];
                            r_ldist[k] <= r_ldist[k-1 > 0 ? k-1 : 0];
                        end
                    end
                end
                r_cnt <= r_cnt + CW'(1);
            end
            r_scan <= r_scan + CW'(1);
            r_ei   <= '0;
        end else if (i_cmd.emit_step) begin
            if (r_ei < r_cnt) begin
                r_ei  <= r_ei + CW'(1);
                r_pos <= r_pos + 3'd1;
            end
            if (o_sts.emit_done) begin
                r_scan <= '0;
                r_cnt  <= '0;
                if (c_last_cl) begin
                    r_cc   <= '0;
                    r_sock <= r_sock + SW'(1);
                    r_pos  <= '0;
                end else begin
                    r_cc <= r_cc + NW'(1);
                end
            end
        end
    end

    assign o_sts.scan_done = i_cmd.scan_step && (r_scan + CW'(1) >= c_n);
    assign o_sts.emit_done = i_cmd.emit_step && (r_ei + CW'(1) >= r_cnt);
    assign o_sts.all_done  = o_sts.emit_done && c_last_grp;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= i_cmd.emit_step && (r_ei < r_cnt);
        end
        o_res.socket_id <= 3'(r_sock);
        o_res.position  <= r_pos;
        o_res.node_id   <= 3'(r_list[r_ei[NW-1:0]]);
        o_res.last      <= o_sts.all_done;
    end

    // cluster numbers never pass the node count
    a_ncl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_step |-> (CW'(r_ncl) < c_n))
        else $error("cluster count overflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_step |-> (r_ei <= r_cnt))
        else $error("emit index past list");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> !o_res_valid)
        else $error("result after last");

endmodule

FILE: src/bandwidth_cluster_fallback_order_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bandwidth_cluster_fallback_order_core: clustered fallback list generator
//
// channel  | signals                         | handshake
// request  | i_start, i_req                  | taken when i_start && !o_busy
// result   | o_res_valid, o_res              | one cycle strobe, no stall
// config   | i_cfg_we, i_cfg_idx, i_cfg_data | written when i_cfg_we
//
// a load is written when taken; a compute keeps busy through the sort, the
// clustering walk with a multiply and a compare step per node, then per socket
// and cluster a scan of the nodes plus an emit of each member; each result
// leaves the result register in the cycle after its emit
// synchronous active-low reset clears counts, config and controller
// results cannot be stalled; the result register holds each for one cycle
// ----------------------------------------------------------------------------
module bandwidth_cluster_fallback_order_core #(
    parameter int MAX_NODES   = bcfo_pkg::MAX_NODES_DEF,
    parameter int MAX_SOCKETS = bcfo_pkg::MAX_SOCKETS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  bcfo_pkg::t_req  i_req,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [6:0]      i_cfg_data,
    output logic            o_res_valid,
    output bcfo_pkg::t_res  o_res
);
    import bcfo_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_acc;

    // request accept
    assign w_acc = i_start && !o_busy;

    bcfo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_acc && i_req.action == ACT_COMPUTE),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    bcfo_dp #(
        .MAX_NODES   (MAX_NODES),
        .MAX_SOCKETS (MAX_SOCKETS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_acc),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
